// ===== hw/rtl/length_prefixed_frame_parser_unit_macros.svh =====
// assertion macros shared by the length-prefixed frame parser rtl
`ifndef LENGTH_PREFIXED_FRAME_PARSER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define LPFP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled during reset
`define LPFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LPFP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define LPFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/lpfp_pkg.sv =====
// types and constants shared by the length-prefixed frame parser modules
`timescale 1ns / 1ps
package lpfp_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_BROKEN = 2'd2
  } lpfp_kind_t;

  localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;

  typedef struct packed {
    lpfp_kind_t  kind;
    logic [31:0] frame_type;
    logic [7:0]  payload_byte;
    logic        last;
  } lpfp_result_t;

endpackage

// ===== hw/rtl/lpfp_front.sv =====
// front end: byte acceptance, header assembly, frame checks and result generation
`timescale 1ns / 1ps
`include "length_prefixed_frame_parser_unit_macros.svh"
module lpfp_front import lpfp_pkg::*; #(
  parameter int FIELD_BYTES = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   byte_value,
  input  logic         cfg_valid,
  input  logic [31:0]  cfg_data,
  input  logic         q_full,
  output logic         push,
  output lpfp_result_t push_data
);

  localparam int IDX_W = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIELD_BYTES - 1);
  localparam logic [32:0] HEADER_LEN = 33'(2 * FIELD_BYTES);

  typedef enum logic [4:0] {
    PH_OUTER   = 5'b00001,
    PH_TYPE    = 5'b00010,
    PH_DLEN    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_BROKEN  = 5'b10000
  } lpfp_phase_t;

  lpfp_phase_t      phase, phase_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [31:0]      outer_length, outer_length_next;
  logic [31:0]      current_type, current_type_next;
  logic [31:0]      payload_left, payload_left_next;
  logic [31:0]      max_frame_length;

  logic             accept;
  logic             word_end;
  logic [31:0]      word_cur;
  logic [31:0]      word_asm;
  logic [IDX_W+2:0] shift;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign word_end = (byte_index == LAST_IDX);
  assign shift    = {byte_index, 3'b000};

  // word currently being assembled
  always_comb begin
    unique case (phase)
      PH_OUTER: word_cur = outer_length;
      PH_TYPE:  word_cur = current_type;
      PH_DLEN:  word_cur = payload_left;
      default:  word_cur = '0;
    endcase
    if (byte_index == '0) begin
      word_asm = 32'(byte_value);
    end else begin
      word_asm = word_cur | (32'(byte_value) << shift);
    end
  end

  always_comb begin
    phase_next        = phase;
    byte_index_next   = byte_index;
    outer_length_next = outer_length;
    current_type_next = current_type;
    payload_left_next = payload_left;
    push              = 1'b0;
    push_data         = '{kind: KIND_BYTE, frame_type: current_type,
                          payload_byte: 8'd0, last: 1'b0};
    if (accept) begin
      unique case (phase)
        PH_OUTER: begin
          outer_length_next = word_asm;
          byte_index_next   = word_end ? '0 : byte_index + 1'b1;
          if (word_end) begin
            if (word_asm > max_frame_length || {1'b0, word_asm} < HEADER_LEN) begin
              phase_next           = PH_BROKEN;
              push                 = 1'b1;
              push_data.kind       = KIND_BROKEN;
              push_data.frame_type = '0;
            end else begin
              phase_next = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          current_type_next = word_asm;
          byte_index_next   = word_end ? '0 : byte_index + 1'b1;
          if (word_end) begin
            phase_next = PH_DLEN;
          end
        end
        PH_DLEN: begin
          payload_left_next = word_asm;
          byte_index_next   = word_end ? '0 : byte_index + 1'b1;
          if (word_end) begin
            if ({1'b0, outer_length} != HEADER_LEN + {1'b0, word_asm}) begin
              phase_next     = PH_BROKEN;
              push           = 1'b1;
              push_data.kind = KIND_BROKEN;
            end else if (word_asm == '0) begin
              phase_next     = PH_OUTER;
              push           = 1'b1;
              push_data.kind = KIND_EMPTY;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          payload_left_next      = payload_left - 32'd1;
          push                   = 1'b1;
          push_data.payload_byte = byte_value;
          if (payload_left == 32'd1) begin
            push_data.last = 1'b1;
            phase_next     = PH_OUTER;
          end
        end
        PH_BROKEN: begin
          phase_next = PH_BROKEN;
        end
        default: begin
          phase_next = PH_BROKEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_OUTER;
      byte_index       <= '0;
      max_frame_length <= MAX_FRAME_RESET;
    end else begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      if (cfg_valid) begin
        max_frame_length <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    outer_length <= outer_length_next;
    current_type <= current_type_next;
    payload_left <= payload_left_next;
  end

  `LPFP_ASSERT_NEXT(a_broken_sticks, clk, rst, phase == PH_BROKEN, phase == PH_BROKEN, "broken state left before reset")
  `LPFP_ASSERT_NOW(a_broken_silent, clk, rst, phase == PH_BROKEN, !push, "result produced after a broken frame")

endmodule

// ===== hw/rtl/lpfp_queue.sv =====
// small result queue between the parser front end and the output stage
`timescale 1ns / 1ps
`include "length_prefixed_frame_parser_unit_macros.svh"
module lpfp_queue import lpfp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  lpfp_result_t push_data,
  output logic         full,
  input  logic         pop,
  output logic         nonempty,
  output lpfp_result_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lpfp_result_t     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `LPFP_ASSERT_NOW(a_no_overflow, clk, rst, push, count != FULL_CNT, "push into a full queue")
  `LPFP_ASSERT_NOW(a_no_underflow, clk, rst, pop, count != '0, "pop from an empty queue")

endmodule

// ===== hw/rtl/lpfp_back.sv =====
// back end: output register that drains the result queue
`timescale 1ns / 1ps
module lpfp_back import lpfp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_nonempty,
  input  lpfp_result_t q_head,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output lpfp_result_t out_item
);

  // refill whenever the output register is empty or its transaction completes
  assign pop = q_nonempty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= q_nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= q_head;
    end
  end

endmodule

// ===== hw/rtl/length_prefixed_frame_parser_unit.sv =====
// top level: an accepted byte's result is written into the queue, then into the output register
// throughput one byte per cycle; the front end never waits on the back end while
// the result queue has room, so output stalls are absorbed up to the queue depth
// reset (rst, synchronous, active high) returns the parser to the outer length,
// sets max_frame_length to 65536, empties the queue and clears the broken state
`timescale 1ns / 1ps
module length_prefixed_frame_parser_unit import lpfp_pkg::*; #(
  parameter int FIELD_BYTES = 4,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  // configuration write channel (max_frame_length)
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // result output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] frame_type,
  output logic [7:0]  payload_byte,
  output logic        last
);

  // results travel front -> queue -> output register
  logic         q_full;
  logic         q_push;
  lpfp_result_t q_push_data;
  logic         q_pop;
  logic         q_nonempty;
  lpfp_result_t q_head;
  lpfp_result_t out_item;

  // the register is a plain flop, so a configuration transaction never stalls
  assign cfg_ready = 1'b1;

  // front end: assembles the three little-endian header words, checks the outer
  // length against the maximum and the header, then tags payload bytes
  lpfp_front #(
    .FIELD_BYTES(FIELD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .byte_value(byte_value),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  // decouples parsing from downstream backpressure
  lpfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  // registered output, one transaction per cycle when the sink keeps up
  lpfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_nonempty(q_nonempty),
    .q_head    (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign kind         = out_item.kind;
  assign frame_type   = out_item.frame_type;
  assign payload_byte = out_item.payload_byte;
  assign last         = out_item.last;

endmodule
